// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the lookup unit.
// Needs nothing else; take it in by a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SCL_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lookup unit assertion failed");

// Clocked assertion that is checked during reset as well.
`define SCL_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lookup unit assertion failed");

`endif

// ===== src/scl_pkg.sv =====
// Shared types and constants of the sorted coordinate table lookup unit.
// Depends on nothing; every other source file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package scl_pkg;

    localparam int COORD_W = 8;
    localparam int WORD_W  = 64;
    localparam int POS_W   = 10;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_SORT   = 2'd1,
        ACT_FIND   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic shift_en;
        logic find_mode;
    } t_cell_ctrl;

    // Compare outcome that a cell hands to its right neighbor.
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cell_flags;

    // One candidate result on its way through the reduction tree.
    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] word;
    } t_leaf;

endpackage

// ===== src/scl_if.sv =====
// Valid/ready channel interfaces for requests and responses of the lookup unit.
// Depends on scl_pkg for the field widths.
`timescale 1ns / 1ps

interface scl_req_if;
    import scl_pkg::*;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [WORD_W-1:0]  entry_word;

    modport source (output valid, action, coord_x, coord_y, coord_z, entry_word,
                    input ready);
    modport sink   (input valid, action, coord_x, coord_y, coord_z, entry_word,
                    output ready);
endinterface

interface scl_rsp_if;
    import scl_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] found_word;

    modport source (output valid, status, position, found_word, input ready);
    modport sink   (input valid, status, position, found_word, output ready);
endinterface

// ===== src/scl_cell.sv =====
// One table entry of the sorted chain: key, payload and its compare logic.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_cell
    import scl_pkg::*;
#(
    parameter int KW    = 24,
    parameter int CW    = 11,
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CW-1:0]     i_count,
    input  logic [KW-1:0]     i_key,
    input  logic [WORD_W-1:0] i_word,
    input  logic [KW-1:0]     i_prev_key,
    input  logic [WORD_W-1:0] i_prev_word,
    input  t_cell_flags       i_prev_flags,
    output logic [KW-1:0]     o_key,
    output logic [WORD_W-1:0] o_word,
    output t_cell_flags       o_flags,
    output t_leaf             o_leaf
);

    logic [KW-1:0]     r_key;
    logic [WORD_W-1:0] r_word;
    logic              occ;
    logic              first;

    assign occ        = CW'(INDEX) < i_count;
    // An empty cell counts as holding a key above every real key.
    assign o_flags.gt = !occ || (r_key > i_key);
    assign o_flags.eq = occ && (r_key == i_key);

    // The sorted order makes both flag runs contiguous, so the edge is unique.
    assign first = i_ctrl.find_mode ? (o_flags.eq && !i_prev_flags.eq)
                                    : (o_flags.gt && !i_prev_flags.gt);

    assign o_leaf.hit  = first;
    assign o_leaf.word = (i_ctrl.find_mode && first) ? r_word : '0;

    assign o_key  = r_key;
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_en) begin
            if (i_prev_flags.gt) begin
                r_key  <= i_prev_key;
                r_word <= i_prev_word;
            end else if (o_flags.gt) begin
                r_key  <= i_key;
                r_word <= i_word;
            end
        end
    end

endmodule

// ===== src/scl_node.sv =====
// Registered four-way merge node of the result tree over the cell chain.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_node
    import scl_pkg::*;
#(
    parameter int PW    = 10,
    parameter int LEVEL = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  t_leaf         i_leaf [4],
    input  logic [PW-1:0] i_pos  [4],
    output t_leaf         o_leaf,
    output logic [PW-1:0] o_pos
);

    logic [1:0]    sel;
    t_leaf         n_leaf;
    logic [PW-1:0] n_pos;
    t_leaf         r_hold_leaf;
    logic [PW-1:0] r_hold_pos;

    // At most one child carries a hit; the others hold zeros.
    assign sel[0] = i_leaf[1].hit | i_leaf[3].hit;
    assign sel[1] = i_leaf[2].hit | i_leaf[3].hit;

    always_comb begin
        n_leaf.hit  = i_leaf[0].hit  | i_leaf[1].hit  | i_leaf[2].hit  | i_leaf[3].hit;
        n_leaf.word = i_leaf[0].word | i_leaf[1].word | i_leaf[2].word | i_leaf[3].word;
        n_pos       = (i_pos[0] | i_pos[1] | i_pos[2] | i_pos[3])
                    | (PW'(sel) << (2 * LEVEL));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hold_leaf <= n_leaf;
            r_hold_pos  <= n_pos;
        end
    end

    assign o_leaf = r_hold_leaf;
    assign o_pos  = r_hold_pos;

endmodule

// ===== src/sorted_coordinate_table_lookup_unit.sv =====
// Top level of the sorted coordinate table lookup unit.
// Depends on scl_pkg, scl_if, scl_cell and scl_node.
`timescale 1ns / 1ps

// The unit keeps up to TABLE_DEPTH entries, each a (y, x, z) coordinate key
// with a 64-bit payload, sorted by key in a chain of cells. Requests arrive
// on i_req and each produces exactly one response on o_rsp; both channels
// move an item when valid and ready are high at a rising clock edge.
// An append request inserts after any equal keys and reports the insertion
// index, a find request reports the first exact match and its payload, and
// a sort request or the unused action code just acknowledges.
// Every cell compares its key against the request in the first search cycle and
// an append shifts the upper part of the chain by one cell in that same cycle.
// The result is then gathered by a registered four-way tree with
// L = ceil(log4(TABLE_DEPTH)) levels, five for the default depth.
// A response is loaded into the output register once the sequencer has run
// through every tree level and the register is free; a new request is taken
// only while the unit is idle, after the previous result has been loaded.
// Reset empties the table at once by clearing the entry count; no sweep of
// the cells is needed. If the receiver stalls, the response waits in the
// output register while the next request is already worked on; a second
// finished result then holds the unit until the register drains.

module sorted_coordinate_table_lookup_unit
    import scl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_BITS  = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scl_req_if.sink   i_req,
    scl_rsp_if.source o_rsp
);

    localparam int KW     = 3 * COORD_BITS;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int L      = ($clog2(TABLE_DEPTH) + 1) / 2;
    localparam int PADDED = 4 ** L;
    localparam int NODES  = (PADDED - 1) / 3;
    localparam int PW     = 2 * L;
    localparam int SW     = (L > 1) ? $clog2(L) : 1;

    // Start of each tree level in the flat node array, bottom level first.
    function automatic int node_off(input int lv);
        int acc;
        acc = 0;
        for (int j = 0; j < lv; j++) begin
            acc = acc + 4 ** (L - 1 - j);
        end
        return acc;
    endfunction

    // Sequencer state.
    t_state          r_state, n_state;
    logic [SW-1:0]   r_step, n_step;
    logic [CW-1:0]   r_count;
    logic            req_acc;
    logic            load_out;

    // Request held for the whole search.
    logic [ACT_W-1:0]  r_action;
    logic [KW-1:0]     r_key;
    logic [WORD_W-1:0] r_word;
    logic              r_full;

    // Output register.
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_found;

    logic [COORD_BITS+COORD_W-1:0] x_ext, y_ext, z_ext;
    logic [KW-1:0]                 req_key;
    t_cell_ctrl                    ctrl;
    logic                          tree_en;

    // Coordinates wider than the key part are cut to its low bits.
    assign x_ext   = {{COORD_BITS{1'b0}}, i_req.coord_x};
    assign y_ext   = {{COORD_BITS{1'b0}}, i_req.coord_y};
    assign z_ext   = {{COORD_BITS{1'b0}}, i_req.coord_z};
    assign req_key = {y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0],
                      z_ext[COORD_BITS-1:0]};

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    // Cells act in the first search cycle; the tree levels then fill in turn.
    assign ctrl.shift_en  = (r_state == S_RUN) && (r_step == '0) &&
                            (r_action == ACT_APPEND) && !r_full;
    assign ctrl.find_mode = (r_action == ACT_FIND);
    assign tree_en        = (r_state == S_RUN);

    // ---------------------------------------------------------------
    // Chain of cells.
    // ---------------------------------------------------------------
    logic [KW-1:0]     cell_key  [TABLE_DEPTH];
    logic [WORD_W-1:0] cell_word [TABLE_DEPTH];
    t_cell_flags       cell_flags[TABLE_DEPTH];
    t_leaf             leaf      [PADDED];

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [KW-1:0]     prev_key;
        logic [WORD_W-1:0] prev_word;
        t_cell_flags       prev_flags;

        if (i == 0) begin : g_head
            assign prev_key   = r_key;
            assign prev_word  = r_word;
            assign prev_flags = '0;
        end else begin : g_link
            assign prev_key   = cell_key[i-1];
            assign prev_word  = cell_word[i-1];
            assign prev_flags = cell_flags[i-1];
        end

        scl_cell #(
            .KW    (KW),
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_count      (r_count),
            .i_key        (r_key),
            .i_word       (r_word),
            .i_prev_key   (prev_key),
            .i_prev_word  (prev_word),
            .i_prev_flags (prev_flags),
            .o_key        (cell_key[i]),
            .o_word       (cell_word[i]),
            .o_flags      (cell_flags[i]),
            .o_leaf       (leaf[i])
        );
    end

    // Padding leaves beyond the table never report a hit.
    for (genvar i = TABLE_DEPTH; i < PADDED; i++) begin : g_pad
        assign leaf[i] = '0;
    end

    // ---------------------------------------------------------------
    // Registered result tree. Each level registers the level below while the
    // sequencer runs, so the root holds the answer for the compare cycle once
    // the sequencer has stepped through every level, and it then holds.
    // ---------------------------------------------------------------
    t_leaf         node_leaf [NODES];
    logic [PW-1:0] node_pos  [NODES];

    for (genvar lv = 0; lv < L; lv++) begin : g_level
        for (genvar n = 0; n < 4 ** (L - 1 - lv); n++) begin : g_node
            t_leaf         ch_leaf [4];
            logic [PW-1:0] ch_pos  [4];

            for (genvar c = 0; c < 4; c++) begin : g_child
                if (lv == 0) begin : g_from_cells
                    assign ch_leaf[c] = leaf[4*n + c];
                    assign ch_pos[c]  = '0;
                end else begin : g_from_nodes
                    assign ch_leaf[c] = node_leaf[node_off(lv - 1) + 4*n + c];
                    assign ch_pos[c]  = node_pos[node_off(lv - 1) + 4*n + c];
                end
            end

            scl_node #(
                .PW    (PW),
                .LEVEL (lv)
            ) u_node (
                .i_clk  (i_clk),
                .i_en   (tree_en),
                .i_leaf (ch_leaf),
                .i_pos  (ch_pos),
                .o_leaf (node_leaf[node_off(lv) + n]),
                .o_pos  (node_pos[node_off(lv) + n])
            );
        end
    end

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (r_step == SW'(L - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (ctrl.shift_en) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_action <= i_req.action;
            r_key    <= req_key;
            r_word   <= i_req.entry_word;
            r_full   <= (r_count == CW'(TABLE_DEPTH));
        end
    end

    // ---------------------------------------------------------------
    // Response formatting and output register.
    // ---------------------------------------------------------------
    t_leaf             root_leaf;
    logic [PW-1:0]     root_pos;
    logic [POS_W+PW-1:0] pos_ext;
    logic [STAT_W-1:0] n_status;
    logic [POS_W-1:0]  n_pos;
    logic [WORD_W-1:0] n_found;

    assign root_leaf = node_leaf[NODES-1];
    assign root_pos  = node_pos[NODES-1];
    assign pos_ext   = {{POS_W{1'b0}}, root_pos};

    always_comb begin
        n_status = ST_DONE;
        n_pos    = '0;
        n_found  = '0;
        case (r_action)
            ACT_APPEND: begin
                if (r_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos = pos_ext[POS_W-1:0];
                end
            end
            ACT_FIND: begin
                if (root_leaf.hit) begin
                    n_pos   = pos_ext[POS_W-1:0];
                    n_found = root_leaf.word;
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_found  <= n_found;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.position   = r_pos;
    assign o_rsp.found_word = r_found;

endmodule

// ===== src/scl_checker.sv =====
// Port-level checker of the lookup unit, attached by the bind at the end.
// Depends on scl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scl_checker
    import scl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [POS_W-1:0]  i_position,
    input logic [WORD_W-1:0] i_found_word
);

    // A stalled response stays offered.
    `SCL_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid)

    // A miss or a dropped append carries neither a position nor a payload.
    `SCL_ASSERT_RST(a_fail_zero, i_clk, i_rst_n, (i_out_valid && (i_status == ST_MISS || i_status == ST_FULL)) |-> (i_position == '0 && i_found_word == '0))

    // Requests are worked on one at a time: after an accept the input closes.
    `SCL_ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)

    // While reset is held no response is offered.
    `SCL_ASSERT_ALL(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind sorted_coordinate_table_lookup_unit scl_checker u_scl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_position   (o_rsp.position),
    .i_found_word (o_rsp.found_word)
);
